FILE: rtl/tsp_pkg.sv
// Shared types, codes and defaults for the timer slot pool.
package tsp_pkg;

  // Default number of timer slots
  localparam int SLOTS_DEF = 8;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int DELAY_W    = 32;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 32;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_COUNTING = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

  // One slot entry as stored in the slot memory
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  deadline;
  } slot_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/tsp_if.sv
// Valid/ready channel interfaces for timer slot pool items and results.
interface tsp_in_if;
  import tsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DELAY_W-1:0]  delay_ticks;
  logic [HANDLE_W-1:0] query_handle;

  modport source (output valid, output kind, output delay_ticks, output query_handle,
                  input ready);
  modport sink   (input valid, input kind, input delay_ticks, input query_handle,
                  output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] granted_handle;

  modport source (output valid, output status, output granted_handle, input ready);
  modport sink   (input valid, input status, input granted_handle, output ready);
endinterface

FILE: rtl/tsp_slot_mem.sv
// Slot memory: one write port, one read port with registered read data.
module tsp_slot_mem #(
  parameter int SLOTS = tsp_pkg::SLOTS_DEF,
  parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tsp_pkg::slot_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output tsp_pkg::slot_t  rdata
);
  import tsp_pkg::*;

  slot_t mem [SLOTS];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/timer_slot_pool_core.sv
// Top level of the timer slot pool: sequencer, counters and output register.
//
// Usage: items arrive on in_ch (kind, delay_ticks, query_handle) and results
// leave on out_ch (status, granted_handle), both valid/ready channels; a
// transfer happens on a clock edge with valid and ready high.
// A tick advances the 32-bit tick count and gives no result. A request takes
// the next slot, hands out the next nonzero handle and stores the deadline;
// it answers STAT_GRANTED or STAT_FULL. A check compares the handle against
// the filled slots and answers counting, expired or invalid.
// Slots fill in order and are never released, so a fill count marks the
// live entries and the slot memory needs no clearing pass.
// A tick is taken in S_IDLE; a request passes through the result registers
// and S_EMIT to the output register; a check walks the slot memory one entry
// per cycle through the single read port, then passes S_EMIT the same way.
// The block takes one item at a time; the next item is accepted as soon as
// the previous result sits in the output register, even if the receiver
// stalls. A stalled receiver holds the output register and, behind it, the
// next result.
// Reset (rst, synchronous) clears the count to 0, the last handle to 1 and
// the fill count to 0, and drops any pending result.
module timer_slot_pool_core #(
  parameter int SLOTS = tsp_pkg::SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  tsp_in_if.sink   in_ch,
  tsp_out_if.source out_ch
);
  import tsp_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t              state, state_next;
  logic [COUNT_W-1:0]  tick_count, tick_count_next;
  logic [HANDLE_W-1:0] last_handle, last_handle_next;
  logic [CW-1:0]       fill, fill_next;
  logic [CW-1:0]       scan_idx, scan_idx_next;
  logic                rd_pend, rd_pend_next;
  logic [HANDLE_W-1:0] query, query_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [HANDLE_W-1:0] res_handle, res_handle_next;
  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_handle;

  logic                accept;
  logic                load_out;
  logic [HANDLE_W-1:0] handle_inc;
  logic                mem_we;
  slot_t               mem_wdata;
  logic                mem_re;
  slot_t               mem_rdata;

  tsp_slot_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill[AW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_out    = (state == S_EMIT) && (!out_valid || out_ch.ready);

  // Next handle, skipping zero on wrap
  always_comb begin
    handle_inc = last_handle + 1'b1;
    if (handle_inc == '0) begin
      handle_inc = HANDLE_W'(1);
    end
  end

  assign mem_wdata.handle   = handle_inc;
  assign mem_wdata.deadline = tick_count + in_ch.delay_ticks;

  // Sequence items: decode, scan slots, hand result to output register
  always_comb begin
    state_next       = state;
    tick_count_next  = tick_count;
    last_handle_next = last_handle;
    fill_next        = fill;
    scan_idx_next    = scan_idx;
    rd_pend_next     = 1'b0;
    query_next       = query;
    res_status_next  = res_status;
    res_handle_next  = res_handle;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.kind)
            KIND_TICK: begin
              tick_count_next = tick_count + 1'b1;
            end
            KIND_REQUEST: begin
              state_next = S_EMIT;
              if (fill < CW'(SLOTS)) begin
                mem_we           = 1'b1;
                fill_next        = fill + 1'b1;
                last_handle_next = handle_inc;
                res_status_next  = STAT_GRANTED;
                res_handle_next  = handle_inc;
              end else begin
                res_status_next = STAT_FULL;
                res_handle_next = '0;
              end
            end
            KIND_CHECK: begin
              query_next      = in_ch.query_handle;
              res_handle_next = '0;
              scan_idx_next   = '0;
              if (in_ch.query_handle == '0) begin
                res_status_next = STAT_INVALID;
                state_next      = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_pend && (mem_rdata.handle == query)) begin
          // Match: lowest slot holding the handle decides
          res_status_next = (tick_count < mem_rdata.deadline) ? STAT_COUNTING
                                                              : STAT_EXPIRED;
          state_next      = S_EMIT;
        end else if (scan_idx < fill) begin
          // Issue the next slot read
          mem_re        = 1'b1;
          rd_pend_next  = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end else if (!rd_pend) begin
          res_status_next = STAT_INVALID;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold output until transferred
  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tick_count  <= '0;
      last_handle <= HANDLE_W'(1);
      fill        <= '0;
      scan_idx    <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      tick_count  <= tick_count_next;
      last_handle <= last_handle_next;
      fill        <= fill_next;
      scan_idx    <= scan_idx_next;
      rd_pend     <= rd_pend_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    query      <= query_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    if (load_out) begin
      out_status <= res_status;
      out_handle <= res_handle;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.granted_handle = out_handle;

endmodule

FILE: tb/sv/timer_slot_pool_core_tb.sv
// Testbench for the timer slot pool core: directed and random traffic checked by a predictor.
module timer_slot_pool_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // Kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [DELAY_W-1:0]  delay_ticks;
    logic [HANDLE_W-1:0] query_handle;
  } timer_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
  } timer_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsp_in_if  in_ch();
  tsp_out_if out_ch();

  timer_slot_pool_core #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predicted pool state, as it stands after every accepted item
  logic [COUNT_W-1:0]  pool_count       = '0;
  logic [HANDLE_W-1:0] pool_last_handle = 16'd1;
  logic [HANDLE_W-1:0] pool_slot_handle   [SLOTS] = '{default: '0};
  logic [COUNT_W-1:0]  pool_slot_deadline [SLOTS] = '{default: '0};

  timer_reply_t replies_due[$];
  int mismatches     = 0;
  int idle_cycles    = 0;
  int in_burst_left  = 0;
  int out_burst_left = 0;
  int stall_left     = 0;

  always #2 clk = ~clk;

  // Pick an idle length: mostly short, a few long, with stretches of none
  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Advance the predicted pool by one item; return 1 when it yields a reply
  function automatic bit predict_timer_reply(input timer_op_t op, output timer_reply_t reply);
    logic [HANDLE_W-1:0] next_handle;
    bit found;
    found = 1'b0;
    predict_timer_reply = 1'b0;
    reply.status = STAT_INVALID;
    reply.granted_handle = '0;
    case (op.kind)
      KIND_TICK: begin
        pool_count = pool_count + 1'b1;
      end
      KIND_REQUEST: begin
        predict_timer_reply = 1'b1;
        reply.status = STAT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && pool_slot_handle[i] == '0) begin
            found = 1'b1;
            next_handle = pool_last_handle + 1'b1;
            // skip zero on wrap
            if (next_handle == '0) next_handle = 16'd1;
            pool_last_handle = next_handle;
            pool_slot_handle[i] = next_handle;
            pool_slot_deadline[i] = pool_count + op.delay_ticks;
            reply.status = STAT_GRANTED;
            reply.granted_handle = next_handle;
          end
        end
      end
      KIND_CHECK: begin
        predict_timer_reply = 1'b1;
        // handle zero never matches, even though free slots hold zero
        if (op.query_handle != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && pool_slot_handle[i] == op.query_handle) begin
              found = 1'b1;
              reply.status = (pool_count < pool_slot_deadline[i]) ? STAT_COUNTING : STAT_EXPIRED;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then predict its reply
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DELAY_W-1:0] delay,
                           input logic [HANDLE_W-1:0] handle);
    timer_op_t op;
    timer_reply_t reply;
    int gap;
    op.kind = kind;
    op.delay_ticks = delay;
    op.query_handle = handle;
    gap = pick_gap(in_burst_left);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.delay_ticks  <= delay;
    in_ch.query_handle <= handle;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_timer_reply(op, reply)) replies_due.push_back(reply);
  endtask

  // Compare one reply against the oldest prediction
  task automatic check_reply(input logic [STATUS_W-1:0] status,
                             input logic [HANDLE_W-1:0] handle);
    timer_reply_t want;
    if (replies_due.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: reply with none pending: status=%0d handle=%0d", $time, status, handle);
      mismatches++;
    end else begin
      want = replies_due.pop_front();
      if (status !== want.status || handle !== want.granted_handle) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: reply mismatch: status exp %0d got %0d, handle exp %0d got %0d",
                   $time, want.status, status, want.granted_handle, handle);
        mismatches++;
      end
    end
  endtask

  // Check each reply transfer and stall the receiver at random
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_reply(out_ch.status, out_ch.granted_handle);
      if (stall_left == 0) stall_left = pick_gap(out_burst_left);
      out_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Ticks and the unused kind give no reply; field contents must not matter
  task automatic test_ignored_items();
    send_item(KIND_TICK, '1, '1);
    send_item(KIND_UNUSED, '1, '1);
    send_item(KIND_UNUSED, '0, '0);
    send_item(KIND_TICK, '0, '0);
  endtask

  // Handle zero and handles held by no slot are invalid
  task automatic test_invalid_handles();
    send_item(KIND_CHECK, '1, '0);
    send_item(KIND_CHECK, '0, '1);
    send_item(KIND_CHECK, '1, 16'd1);
    send_item(KIND_CHECK, '0, 16'h5555);
    send_item(KIND_CHECK, '1, 16'hAAAA);
    send_item(KIND_CHECK, '0, 16'd2);
  endtask

  // Grant handles and watch deadlines pass, including a wrapped deadline
  task automatic test_grant_and_expiry();
    send_item(KIND_REQUEST, '0, '1);
    send_item(KIND_CHECK, '1, 16'd2);
    send_item(KIND_REQUEST, '1, '0);
    send_item(KIND_CHECK, '0, 16'd3);
    send_item(KIND_REQUEST, 32'h8000_0000, '1);
    send_item(KIND_CHECK, '1, 16'd4);
    send_item(KIND_REQUEST, 32'd3, '0);
    send_item(KIND_CHECK, '0, 16'd5);
    send_item(KIND_TICK, '0, '0);
    send_item(KIND_TICK, '1, '1);
    send_item(KIND_CHECK, '1, 16'd5);
    send_item(KIND_TICK, '0, '1);
    send_item(KIND_CHECK, '0, 16'd5);
  endtask

  // Mixed traffic: ticks, requests with mostly short delays, checks near live handles
  task automatic test_random_traffic();
    int r;
    logic [KIND_W-1:0]   kind;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      delay = $urandom;
      handle = HANDLE_W'($urandom);
      if (r < 40) begin
        kind = KIND_TICK;
      end else if (r < 52) begin
        kind = KIND_REQUEST;
        r = $urandom_range(0, 9);
        if (r < 7) delay = $urandom_range(0, 400);
        else if (r == 7) delay = '1;
        else if (r == 8) delay = '0;
      end else if (r < 95) begin
        kind = KIND_CHECK;
        r = $urandom_range(0, 9);
        if (r < 7) handle = HANDLE_W'($urandom_range(1, pool_last_handle + 2));
        else if (r == 7) handle = '0;
      end else begin
        kind = KIND_UNUSED;
      end
      send_item(kind, delay, handle);
    end
  endtask

  // Every slot is taken by now: requests must be refused, handles still answer
  task automatic test_pool_full();
    send_item(KIND_REQUEST, '0, '1);
    send_item(KIND_REQUEST, '1, '0);
    for (int h = 2; h <= SLOTS + 2; h++) send_item(KIND_CHECK, '1, HANDLE_W'(h));
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_TICK;
    in_ch.delay_ticks  = '0;
    in_ch.query_handle = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_ignored_items();
    test_invalid_handles();
    test_grant_and_expiry();
    test_random_traffic();
    test_pool_full();
    in_ch.valid <= 1'b0;

    // drain outstanding replies, then watch for strays
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/tsp_pkg.sv
rtl/tsp_if.sv
rtl/tsp_slot_mem.sv
rtl/timer_slot_pool_core.sv
tb/sv/timer_slot_pool_core_tb.sv
